/* hw/rtl/qdd_pkg.sv */
// Shared types, constants and the transition table for the quadrature detent decoder.
package qdd_pkg;

  // Sample ring geometry; holds at most RING_DEPTH-1 samples
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field widths
  localparam int AB_W     = 2;
  localparam int DELTA_W  = 7;
  localparam int CFG_IDX_W = 2;

  // Port widths (tdata in whole bytes)
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_PRESENT   = 2'd1;

  // Input commands
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_POLL    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } state_t;

  // Ring control and status between sequencer and ring
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            clear;
    logic [AB_W-1:0] push_ab;
  } ring_ctl_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [AB_W-1:0] rd_ab;
  } ring_stat_t;

  // Result of one pass through the step unit
  typedef struct packed {
    logic signed [1:0] acc;
    logic signed [1:0] detent;
  } step_res_t;

  // Result word, dropped in the top bit
  typedef struct packed {
    logic                      dropped;
    logic                      pressed;
    logic signed [DELTA_W-1:0] delta;
  } out_word_t;

  // Quarter steps for a {previous, current} pin transition
  function automatic logic signed [1:0] transition_step(input logic [3:0] idx);
    logic signed [1:0] q;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: q = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: q = 2'sd1;
      default: q = 2'sd0;
    endcase
    return q;
  endfunction

endpackage

/* hw/rtl/qdd_ring.sv */
// Sample ring: storage array with head/tail pointers and a registered read port.
module qdd_ring (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qdd_pkg::ring_ctl_t     ctl,
  output qdd_pkg::ring_stat_t    stat
);
  import qdd_pkg::*;

  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

  logic [AB_W-1:0]    mem [RING_DEPTH];
  logic [AB_W-1:0]    rd_ab_r;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [RING_AW-1:0] tail_r, tail_nxt;
  logic [RING_AW-1:0] tail_inc, head_inc;
  logic               full, empty;

  // Pointer increments with wrap at the last slot
  assign tail_inc = (tail_r == RING_LAST) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == RING_LAST) ? '0 : head_r + 1'b1;
  assign full     = (tail_inc == head_r);
  assign empty    = (tail_r == head_r);

  // Next pointer values
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.push && !full) tail_nxt = tail_inc;
      if (ctl.pop && !empty) head_nxt = head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctl.push && !full && !ctl.clear) mem[tail_r] <= ctl.push_ab;
    rd_ab_r <= mem[head_r];
  end

  assign stat.empty = empty;
  assign stat.full  = full;
  assign stat.rd_ab = rd_ab_r;

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(empty && full)) else $error("ring reports empty and full together");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> empty) else $error("ring not empty after clear");

  a_push_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && full && !ctl.pop && !ctl.clear) |=> $stable(tail_r))
    else $error("tail moved on a push into a full ring");

endmodule

/* hw/rtl/qdd_step_unit.sv */
// Shared step unit: transition lookup, quarter accumulation and detent decision.
module qdd_step_unit (
  input  logic                       invert,
  input  logic [qdd_pkg::AB_W-1:0]   prev_ab,
  input  logic [qdd_pkg::AB_W-1:0]   cur_ab,
  input  logic signed [1:0]          acc,
  output qdd_pkg::step_res_t         res
);
  import qdd_pkg::*;

  logic signed [1:0] q;
  logic signed [2:0] sum;

  assign q   = transition_step({prev_ab, cur_ab});
  assign sum = 3'(acc) + 3'(q);

  // A full detent clears the accumulator; direction flips when inverted
  always_comb begin
    res.acc    = sum[1:0];
    res.detent = 2'sd0;
    if (q == 2'sd0) begin
      res.acc = acc;
    end else if (sum >= 3'sd2) begin
      res.acc    = 2'sd0;
      res.detent = invert ? -2'sd1 : 2'sd1;
    end else if (sum <= -3'sd2) begin
      res.acc    = 2'sd0;
      res.detent = invert ? 2'sd1 : -2'sd1;
    end
  end

endmodule

/* hw/rtl/quadrature_detent_decoder.sv */
// Quadrature detent decoder top: command sequencer, config registers and result register.
// Sample, poll and restart words reach the result register in the cycle after they are accepted.
// A read pushes its own sample, then drains the ring one sample per FETCH/STEP pair,
// through the single ring read port feeding the one shared step unit.
// in_tready is low while a read drains and while an untaken result blocks a new one.
// Synchronous active-low reset empties the ring and clears pointers, accumulator and
// previous pins; previous button reads released; invert 0, button present 1.
module quadrature_detent_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [1:0] ab_pins, [2] button_level
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [qdd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: [1:0] command
  input  logic [qdd_pkg::IN_TUSER_W-1:0]       in_tuser,
  // out_tdata: [6:0] delta_detents, [7] pressed, [8] dropped
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [qdd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic                                 cfg_data
);
  import qdd_pkg::*;

  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_word_r, out_word_nxt;
  logic [AB_W-1:0]           prev_ab_r, prev_ab_nxt;
  logic signed [1:0]         acc_r, acc_nxt;
  logic signed [DELTA_W-1:0] detents_r, detents_nxt;
  logic                      drop_r, drop_nxt;
  logic                      prev_btn_r, prev_btn_nxt;
  logic                      invert_r, btn_present_r;

  ring_ctl_t                 ring_ctl;
  ring_stat_t                ring_stat;
  step_res_t                 step_res;

  logic                      in_accept;
  logic                      out_free;
  cmd_t                      cmd;
  logic [AB_W-1:0]           in_ab;
  logic                      in_level;

  assign cmd       = cmd_t'(in_tuser);
  assign in_ab     = in_tdata[AB_W-1:0];
  assign in_level  = in_tdata[AB_W];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_tvalid && in_tready;

  qdd_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .stat  (ring_stat)
  );

  qdd_step_unit u_step (
    .invert  (invert_r),
    .prev_ab (prev_ab_r),
    .cur_ab  (ring_stat.rd_ab),
    .acc     (acc_r),
    .res     (step_res)
  );

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r      <= 1'b0;
      btn_present_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INVERT_DIRECTION: invert_r      <= cfg_data;
        REG_BUTTON_PRESENT:   btn_present_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, ring control and result word
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    prev_ab_nxt   = prev_ab_r;
    acc_nxt       = acc_r;
    detents_nxt   = detents_r;
    drop_nxt      = drop_r;
    prev_btn_nxt  = prev_btn_r;
    ring_ctl      = '0;
    ring_ctl.push_ab = in_ab;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_word_nxt  = '0;
          out_valid_nxt = 1'b1;
          case (cmd)
            CMD_SAMPLE: begin
              ring_ctl.push        = 1'b1;
              out_word_nxt.dropped = ring_stat.full;
            end
            CMD_READ: begin
              ring_ctl.push = 1'b1;
              drop_nxt      = ring_stat.full;
              detents_nxt   = '0;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_FETCH;
            end
            CMD_POLL: begin
              if (btn_present_r) begin
                out_word_nxt.pressed = prev_btn_r && !in_level;
                prev_btn_nxt         = in_level;
              end
            end
            default: begin
              ring_ctl.clear = 1'b1;
              prev_ab_nxt    = in_ab;
              acc_nxt        = 2'sd0;
              if (btn_present_r) prev_btn_nxt = in_level;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Head word is captured by the ring read port at this edge
        if (ring_stat.empty) begin
          if (out_free) begin
            out_valid_nxt        = 1'b1;
            out_word_nxt.dropped = drop_r;
            out_word_nxt.pressed = 1'b0;
            out_word_nxt.delta   = detents_r;
            state_nxt            = ST_IDLE;
          end
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        ring_ctl.pop = 1'b1;
        prev_ab_nxt  = ring_stat.rd_ab;
        acc_nxt      = step_res.acc;
        detents_nxt  = detents_r + DELTA_W'(step_res.detent);
        state_nxt    = ST_FETCH;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_ab_r   <= '0;
      acc_r       <= 2'sd0;
      prev_btn_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_ab_r   <= prev_ab_nxt;
      acc_r       <= acc_nxt;
      prev_btn_r  <= prev_btn_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    detents_r  <= detents_nxt;
    drop_r     <= drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_word_r);

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r != -2'sd2) else $error("quarter accumulator left at a full detent");

  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH && ring_stat.empty && out_free)
      |=> (out_valid_r && state_r == ST_IDLE))
    else $error("drain finished without a result");

  a_step_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> !ring_stat.empty)
    else $error("step on an empty ring");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted while draining");

endmodule

/* verif/tb_quadrature_detent_decoder.sv */
// Self-checking testbench for the quadrature detent decoder: directed and random words.
module tb_quadrature_detent_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import qdd_pkg::*;

  // Register indexes outside the map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int QUARTERS_PER_DETENT = 2;
  localparam int DRAIN_CYCLES        = 2 * (RING_DEPTH - 1) + 2;

  // Quarter steps indexed by {previous pins, current pins}
  localparam int QUARTER_STEP [16] = '{ 0, -1,  1,  0,
                                        1,  0,  0, -1,
                                       -1,  0,  0,  1,
                                        0,  1, -1,  0};

  typedef struct {
    cmd_t            cmd;
    logic [AB_W-1:0] ab;
    logic            level;
  } encoder_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic                   cfg_data = 1'b0;

  quadrature_detent_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Stimulus and scoreboard stores
  encoder_word_t   encoder_words[$];
  out_word_t       expected_results[$];
  int unsigned     issued_cnt;
  int unsigned     accepted_cnt;
  int unsigned     cfg_writes;
  int unsigned     mismatch_cnt;

  // Decoder shadow state
  logic [AB_W-1:0] sample_fifo[$];
  logic [AB_W-1:0] last_ab;
  int              quarter_acc;
  logic            last_button;
  logic            invert_dir;
  logic            button_fitted;

  // Generator's idea of where the knob sits
  logic [AB_W-1:0] knob_ab;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Expected result of one command word; advances the shadow state
  function automatic out_word_t predict_decoder_word(input encoder_word_t w);
    out_word_t       res;
    int              detents;
    int              q;
    logic [AB_W-1:0] cur;
    res = '0;
    detents = 0;
    case (w.cmd)
      CMD_SAMPLE, CMD_READ: begin
        if (sample_fifo.size() == RING_DEPTH - 1) res.dropped = 1'b1;
        else sample_fifo.push_back(w.ab);
        if (w.cmd == CMD_READ) begin
          while (sample_fifo.size() > 0) begin
            cur = sample_fifo.pop_front();
            q = QUARTER_STEP[{last_ab, cur}];
            last_ab = cur;
            if (q != 0) begin
              quarter_acc += q;
              if (quarter_acc >= QUARTERS_PER_DETENT) begin
                quarter_acc = 0;
                detents += invert_dir ? -1 : 1;
              end else if (quarter_acc <= -QUARTERS_PER_DETENT) begin
                quarter_acc = 0;
                detents += invert_dir ? 1 : -1;
              end
            end
          end
          res.delta = detents[DELTA_W-1:0];
        end
      end
      CMD_POLL: begin
        if (button_fitted) begin
          res.pressed = last_button & ~w.level;
          last_button = w.level;
        end
      end
      default: begin
        sample_fifo.delete();
        last_ab = w.ab;
        quarter_acc = 0;
        if (button_fitted) last_button = w.level;
      end
    endcase
    return res;
  endfunction

  // Driver: sender bursts with random gaps, fed from encoder_words
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin : sender
    encoder_word_t w;
    if (rst_n) begin
      if (in_tvalid && issued_cnt != accepted_cnt) begin
        // word still waiting for in_tready
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (encoder_words.size() > 0) begin
        w = encoder_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'({w.level, w.ab});
        in_tuser  <= w.cmd;
        issued_cnt++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: switches to a random one of four modes after each random span
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin : receiver
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 120);
    end else begin
      stall_span--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (stall_tick % 4 != 0);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Monitor: config and input accepts feed the predictor, results are checked
  always @(posedge clk) begin : monitor
    out_word_t     got;
    out_word_t     want;
    encoder_word_t w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INVERT_DIRECTION) invert_dir = cfg_data;
        else if (cfg_index == REG_BUTTON_PRESENT) button_fitted = cfg_data;
        cfg_writes++;
      end
      if (out_tvalid && out_tready) begin
        got = out_word_t'(out_tdata[$bits(out_word_t)-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word 0x%h with nothing outstanding", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.delta !== want.delta)
            report_mismatch($sformatf("delta_detents %0d, want %0d", got.delta, want.delta));
          if (got.pressed !== want.pressed)
            report_mismatch($sformatf("pressed %b, want %b", got.pressed, want.pressed));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %b, want %b", got.dropped, want.dropped));
          if (out_tdata[OUT_TDATA_W-1:$bits(out_word_t)] !== '0)
            report_mismatch($sformatf("pad bits set in result word 0x%h", out_tdata));
        end
      end
      if (in_tvalid && in_tready) begin
        w.cmd   = cmd_t'(in_tuser);
        w.ab    = in_tdata[AB_W-1:0];
        w.level = in_tdata[AB_W];
        expected_results.push_back(predict_decoder_word(w));
        accepted_cnt++;
      end
    end
  end

  task automatic queue_word(input cmd_t cmd, input logic [AB_W-1:0] ab, input logic level);
    encoder_word_t w;
    w.cmd = cmd;
    w.ab = ab;
    w.level = level;
    encoder_words.push_back(w);
  endtask

  // Next pin state one quarter step along the Gray sequence 0,1,3,2
  function automatic logic [AB_W-1:0] gray_step(input logic [AB_W-1:0] ab, input bit fwd);
    case (ab)
      2'd0: return fwd ? 2'd1 : 2'd2;
      2'd1: return fwd ? 2'd3 : 2'd0;
      2'd3: return fwd ? 2'd2 : 2'd1;
      default: return fwd ? 2'd0 : 2'd3;
    endcase
  endfunction

  // Turn the knob n quarter steps, with an occasional bounce back
  task automatic queue_rotation(input int n, input bit fwd);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) knob_ab = gray_step(knob_ab, !fwd);
      else knob_ab = gray_step(knob_ab, fwd);
      queue_word(CMD_SAMPLE, knob_ab, 1'($urandom_range(0, 1)));
    end
  endtask

  // Random phase: mostly clean rotations and reads, plus polls, noise and restarts
  task automatic queue_random_phase(input int n);
    int unsigned start;
    int          pick;
    int          len;
    start = encoder_words.size();
    // one run of RING_DEPTH-4 to RING_DEPTH+4 samples, ending in a read
    len = $urandom_range(RING_DEPTH - 4, RING_DEPTH + 4);
    for (int i = 0; i < len; i++) begin
      knob_ab = gray_step(knob_ab, 1'b1);
      queue_word(CMD_SAMPLE, knob_ab, 1'($urandom_range(0, 1)));
    end
    queue_word(CMD_READ, gray_step(knob_ab, 1'b1), 1'($urandom_range(0, 1)));
    knob_ab = gray_step(knob_ab, 1'b1);
    while (encoder_words.size() - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_rotation($urandom_range(1, 14), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) begin
          knob_ab = gray_step(knob_ab, 1'($urandom_range(0, 1)));
          queue_word(CMD_READ, knob_ab, 1'($urandom_range(0, 1)));
        end
      end else if (pick < 70) begin
        queue_word(CMD_READ, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4))
          queue_word(CMD_POLL, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 5)) begin
          knob_ab = 2'($urandom_range(0, 3));
          queue_word(CMD_SAMPLE, knob_ab, 1'($urandom_range(0, 1)));
        end
      end else if (pick < 96) begin
        knob_ab = 2'($urandom_range(0, 3));
        queue_word(CMD_RESTART, knob_ab, 1'($urandom_range(0, 1)));
      end else begin
        // long run without a read, often overflowing the ring
        queue_rotation($urandom_range(30, RING_DEPTH + 8), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (encoder_words.size() != 0 || issued_cnt != accepted_cnt ||
           expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic val);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    last_ab       = '0;
    quarter_acc   = 0;
    last_button   = 1'b1;
    invert_dir    = 1'b0;
    button_fitted = 1'b1;
    knob_ab       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all commands, pin and level extremes, invalid and idle transitions
    queue_word(CMD_RESTART, 2'd0, 1'b1);
    queue_word(CMD_SAMPLE,  2'd1, 1'b0);
    queue_word(CMD_SAMPLE,  2'd3, 1'b1);
    queue_word(CMD_SAMPLE,  2'd2, 1'b0);
    queue_word(CMD_READ,    2'd0, 1'b1);
    queue_word(CMD_SAMPLE,  2'd3, 1'b0);   // both pins change
    queue_word(CMD_SAMPLE,  2'd3, 1'b1);   // no change
    queue_word(CMD_SAMPLE,  2'd1, 1'b0);
    queue_word(CMD_READ,    2'd0, 1'b0);
    queue_word(CMD_READ,    2'd2, 1'b1);   // read with only its own sample
    queue_word(CMD_POLL,    2'd0, 1'b1);
    queue_word(CMD_POLL,    2'd3, 1'b0);   // falling edge
    queue_word(CMD_POLL,    2'd0, 1'b0);
    queue_word(CMD_POLL,    2'd1, 1'b1);
    queue_word(CMD_SAMPLE,  2'd0, 1'b0);
    queue_word(CMD_RESTART, 2'd3, 1'b0);   // reload pins, button held low
    queue_word(CMD_POLL,    2'd2, 1'b0);
    queue_word(CMD_SAMPLE,  2'd2, 1'b1);
    queue_word(CMD_SAMPLE,  2'd0, 1'b1);
    queue_word(CMD_READ,    2'd1, 1'b1);
    queue_word(CMD_RESTART, 2'd2, 1'b1);
    queue_word(CMD_READ,    2'd2, 1'b0);
    wait_drained();
    knob_ab = 2'd2;

    // Out-of-range indexes, then the reset settings
    write_register(REG_SPARE_2, 1'b1);
    write_register(REG_SPARE_3, 1'b1);
    queue_random_phase(360);
    wait_drained();

    write_register(REG_INVERT_DIRECTION, 1'b1);
    queue_random_phase(360);
    wait_drained();

    write_register(REG_INVERT_DIRECTION, 1'b0);
    write_register(REG_BUTTON_PRESENT, 1'b0);
    queue_random_phase(360);
    wait_drained();

    write_register(REG_INVERT_DIRECTION, 1'b1);
    queue_random_phase(360);
    wait_drained();

    write_register(REG_INVERT_DIRECTION, 1'b0);
    write_register(REG_BUTTON_PRESENT, 1'b1);
    queue_random_phase(360);
    wait_drained();

    // catch any late stray result words
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
